### src/gstd_pkg.sv
// Shared types, constants and register codes of the grouped signal trace decoder.
package gstd_pkg;

    // Capture channels and sample width
    localparam int CHANNELS  = 15;
    localparam int SAMPLE_W  = 15;
    localparam int GROUP_W   = 4;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_START_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT       = 2'd2;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] START_MASK_RST = 15'h0001;
    localparam logic [COUNT_W-1:0]  CHAN_COUNT_RST = 4'd15;
    localparam logic [TIME_W-1:0]   TIME_LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0]   TIME_MAX       = 32'hFFFF_FFFF;

    // Input request
    typedef struct packed {
        logic [31:0] trace_word;
        logic        first_word;
    } t_in;

    // Output request: one group change
    typedef struct packed {
        logic [TIME_W-1:0]   event_time;
        logic [GROUP_W-1:0]  group_index;
        logic [SAMPLE_W-1:0] group_value;
        logic                last_event;
    } t_out;

    // One sample to be split into group events
    typedef struct packed {
        logic [TIME_W-1:0]   time_stamp;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] diff;
        logic                last;
    } t_job;

    // Decoded configuration
    typedef struct packed {
        logic [SAMPLE_W-1:0] start;
        logic [SAMPLE_W-1:0] used;
        logic [COUNT_W-1:0]  nch;
        logic [TIME_W-1:0]   limit;
    } t_cfg;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### src/gstd_front.sv
// Front end: accepts trace words, keeps trace time and splits words into sample jobs.
module gstd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gstd_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    input  gstd_pkg::t_in   i_in,
    output logic            o_in_stall,
    input  gstd_pkg::t_qstat i_qstat,
    output logic            o_push,
    output gstd_pkg::t_job  o_job
);
    import gstd_pkg::*;

    logic [TIME_W-1:0]   r_time, n_time;
    logic [SAMPLE_W-1:0] r_prev, n_prev;
    logic                r_stopped, n_stopped;
    t_job                r_slot0, r_slot1, n_slot0, n_slot1;
    logic                r_h0v, r_h1v, n_h0v, n_h1v;

    logic                accept, run, first, blocked, stop1;
    logic [31:0]         word;
    logic [TIME_W-1:0]   eff_time, t_run, t1, t2;
    logic [TIME_W:0]     run_sum;
    logic [SAMPLE_W-1:0] s0, s1, prev, d0, d1;
    logic                j0v, j1v;
    t_job                j0, j1;

    // Push the head slot whenever the queue has room
    assign o_push     = r_h0v && !i_qstat.full;
    assign o_job      = r_slot0;
    assign o_in_stall = r_h1v || (r_h0v && i_qstat.full);
    assign accept     = i_in_valid && !o_in_stall;

    // Decode the word and advance trace time
    always_comb begin
        word     = i_in.trace_word;
        first    = i_in.first_word;
        run      = word[31];
        eff_time = first ? '0 : r_time;
        blocked  = !first && r_stopped;
        s0       = run ? word[30:16] : word[14:0];
        s1       = word[30:16];
        prev     = first ? ~s0 : r_prev;
        d0       = (s0 ^ prev) & i_cfg.used;
        d1       = (s1 ^ s0) & i_cfg.used;

        run_sum  = {1'b0, eff_time} + {16'd0, word[15:0], 1'b0};
        t_run    = run_sum[TIME_W] ? TIME_MAX : run_sum[TIME_W-1:0];
        t1       = (eff_time == TIME_MAX) ? TIME_MAX : eff_time + 1'b1;
        stop1    = t1 > i_cfg.limit;
        t2       = (t1 == TIME_MAX) ? TIME_MAX : t1 + 1'b1;

        j1v      = !run && !stop1 && (d1 != '0);
        j0v      = d0 != '0;
        j0       = '{time_stamp: eff_time, sample: s0, diff: d0, last: !j1v};
        j1       = '{time_stamp: t1, sample: s1, diff: d1, last: 1'b1};

        if (run) begin
            n_time    = t_run;
            n_prev    = s0;
            n_stopped = t_run > i_cfg.limit;
        end else if (stop1) begin
            n_time    = t1;
            n_prev    = s0;
            n_stopped = 1'b1;
        end else begin
            n_time    = t2;
            n_prev    = s1;
            n_stopped = t2 > i_cfg.limit;
        end
    end

    // Advance the job slots
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_h0v   = r_h0v;
        n_h1v   = r_h1v;
        if (o_push) begin
            n_slot0 = r_slot1;
            n_h0v   = r_h1v;
            n_h1v   = 1'b0;
        end
        if (accept && !blocked) begin
            if (j0v) begin
                n_slot0 = j0;
                n_slot1 = j1;
                n_h0v   = 1'b1;
                n_h1v   = j1v;
            end else begin
                n_slot0 = j1;
                n_h0v   = j1v;
                n_h1v   = 1'b0;
            end
        end
    end

    // Hold decoder state and slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_prev    <= '0;
            r_stopped <= 1'b0;
            r_h0v     <= 1'b0;
            r_h1v     <= 1'b0;
        end else begin
            r_h0v <= n_h0v;
            r_h1v <= n_h1v;
            if (accept && !blocked) begin
                r_time    <= n_time;
                r_prev    <= n_prev;
                r_stopped <= n_stopped;
            end
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

### src/gstd_queue.sv
// Short job queue between the front end and the event generator.
module gstd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gstd_pkg::t_job   i_job,
    input  logic             i_pop,
    output gstd_pkg::t_job   o_job,
    output gstd_pkg::t_qstat o_stat
);
    import gstd_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/gstd_back.sv
// Back end: walks a job's changed groups, one event per cycle unless stalled.
module gstd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gstd_pkg::t_cfg   i_cfg,
    input  gstd_pkg::t_job   i_job,
    input  gstd_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_out_valid,
    output gstd_pkg::t_out   o_out,
    input  logic             i_out_stall
);
    import gstd_pkg::*;

    logic [SAMPLE_W-1:0] r_pend, r_sample;
    logic [TIME_W-1:0]   r_time;
    logic                r_last;
    t_out                r_out;
    logic                r_ovalid;

    logic                active, load, emit;
    logic [GROUP_W-1:0]  k, gs, ge;
    logic [SAMPLE_W-1:0] gmask, lowmask, rest;
    t_out                ev;

    // Locate the group of the lowest pending changed channel
    always_comb begin
        k  = '0;
        gs = '0;
        ge = i_cfg.nch;
        for (int i = SAMPLE_W - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                k = GROUP_W'(i);
            end
        end
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (i_cfg.start[i] && GROUP_W'(i) <= k) begin
                gs = GROUP_W'(i);
            end
        end
        for (int i = SAMPLE_W - 1; i >= 0; i--) begin
            if (i_cfg.start[i] && GROUP_W'(i) > k) begin
                ge = GROUP_W'(i);
            end
        end
        for (int i = 0; i < SAMPLE_W; i++) begin
            gmask[i]   = (GROUP_W'(i) >= gs) && (GROUP_W'(i) < ge);
            lowmask[i] = GROUP_W'(i) <= k;
        end
        rest = r_pend & ~gmask;
        ev.event_time  = r_time;
        ev.group_index = GROUP_W'($countones(i_cfg.start & lowmask) - 1);
        ev.group_value = (r_sample & gmask) >> gs;
        ev.last_event  = r_last && (rest == '0);
    end

    assign active      = r_pend != '0;
    assign load        = !r_ovalid || !i_out_stall;
    assign emit        = active && load;
    assign o_pop       = !i_qstat.empty && (!active || (load && rest == '0));
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // Hold the current job and the output request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pend <= i_job.diff;
            end else if (emit) begin
                r_pend <= rest;
            end
            if (load) begin
                r_ovalid <= active;
            end
        end
        if (o_pop) begin
            r_sample <= i_job.sample;
            r_time   <= i_job.time_stamp;
            r_last   <= i_job.last;
        end
        if (emit) begin
            r_out <= ev;
        end
    end

endmodule

### src/grouped_signal_trace_decoder_top.sv
// Top level of the grouped signal trace decoder: configuration registers and wiring.
//
// Input channel (i_in_valid, i_in, o_in_stall): one request per 32-bit trace word,
// with first_word restarting trace time at zero and reporting every group.
// Output channel (o_out_valid, o_out, i_out_stall): one request per changed
// group, with last_event marking the final change caused by a word.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is high,
// only while the block is idle.
// Throughput: the front end makes at most one job of a run word or of a two-sample
// word in which one sample changes a group; when both change a group, the input
// stalls while the second job waits, and jobs go one push per cycle, while there is
// room, into the four-entry job queue. The back end sends one event per changed
// group, one per cycle unless the output stalls; a queued job is loaded as its
// predecessor sends its last event; one reaching an idle back end is loaded first.
// A word's first event passes a job slot, the queue, the job and output registers.
// Reset (synchronous, active low) restores the register defaults, clears trace
// time, the stop flag and the previous sample, and empties the queue.
// A stall on the output holds the event register; the queue then fills and
// o_in_stall rises, so no event is lost.
module grouped_signal_trace_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  gstd_pkg::t_in                      i_in,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output gstd_pkg::t_out                     o_out,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_we,
    input  logic [gstd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gstd_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import gstd_pkg::*;

    logic [SAMPLE_W-1:0] r_start_mask;
    logic [COUNT_W-1:0]  r_chan_count;
    logic [TIME_W-1:0]   r_time_limit;

    t_cfg   cfg;
    t_qstat qstat;
    t_job   push_job, head_job;
    logic   push, pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mask <= START_MASK_RST;
            r_chan_count <= CHAN_COUNT_RST;
            r_time_limit <= TIME_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GROUP_START_MASK: r_start_mask <= i_cfg_data[SAMPLE_W-1:0];
                CFG_CHANNEL_COUNT:    r_chan_count <= i_cfg_data[COUNT_W-1:0];
                CFG_TIME_LIMIT:       r_time_limit <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the channel count and derive the group starts
    always_comb begin
        cfg.nch   = (r_chan_count > COUNT_W'(CHANNELS)) ? COUNT_W'(CHANNELS) : r_chan_count;
        cfg.used  = SAMPLE_W'((17'd1 << cfg.nch) - 17'd1);
        cfg.start = (r_start_mask & cfg.used) | SAMPLE_W'(1);
        cfg.limit = r_time_limit;
    end

    gstd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    gstd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    gstd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

### src/gstd_checker.sv
// Port-level checks of the grouped signal trace decoder and their binding.
module gstd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input gstd_pkg::t_out o_out,
    input logic           i_out_stall
);
    import gstd_pkg::*;

    // Keep a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped under stall");

    // Keep a stalled output payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("output payload changed under stall");

    // Empty the output after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output request present after reset");

    // Accept input straight after reset
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind grouped_signal_trace_decoder_top gstd_checker u_gstd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out       (o_out),
    .i_out_stall (i_out_stall)
);

### tb/grouped_signal_trace_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the grouped signal trace decoder: directed and random trace words, checked by a predictor.
module grouped_signal_trace_decoder_top_tb;
    import gstd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_RUNS     = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in        = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    grouped_signal_trace_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Register copies seen by the predictor
    logic [SAMPLE_W-1:0] start_mask_cfg = START_MASK_RST;
    logic [COUNT_W-1:0]  chan_count_cfg = CHAN_COUNT_RST;
    logic [TIME_W-1:0]   limit_cfg      = TIME_LIMIT_RST;

    // Decoder state seen by the predictor
    logic [TIME_W-1:0]   tick_now    = '0;
    logic [SAMPLE_W-1:0] last_sample = '0;
    logic                halted      = 1'b0;

    t_in  pending_words[$];
    t_out expected_events[$];
    t_out word_events[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int in_gap         = 0;
    int in_calm        = 0;
    int out_hold       = 0;
    int out_calm       = 0;
    logic [SAMPLE_W-1:0] gen_sample = '0;

    // Saturating tick addition
    function automatic logic [TIME_W-1:0] add_ticks(input logic [TIME_W-1:0] a,
                                                     input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Append one event per group whose bits differ between prev and smp
    task automatic collect_group_changes(input logic [TIME_W-1:0] stamp,
                                         input logic [SAMPLE_W-1:0] smp,
                                         input logic [SAMPLE_W-1:0] prev);
        int nch;
        int grp;
        int lo;
        logic [SAMPLE_W:0]   starts;
        logic [SAMPLE_W-1:0] diff;
        logic [SAMPLE_W-1:0] span;
        t_out ev;
        nch = (chan_count_cfg > CHANNELS) ? CHANNELS : int'(chan_count_cfg);
        starts = {1'b0, start_mask_cfg};
        starts[0] = 1'b1;
        starts[nch] = 1'b1;
        diff = smp ^ prev;
        grp = -1;
        lo = 0;
        span = '0;
        for (int ch = 0; ch <= nch; ch++) begin
            if (starts[ch]) begin
                if (ch > 0 && (diff & span) != '0) begin
                    ev.event_time  = stamp;
                    ev.group_index = grp[GROUP_W-1:0];
                    ev.group_value = (smp & span) >> lo;
                    ev.last_event  = 1'b0;
                    word_events = {word_events, ev};
                end
                grp++;
                lo = ch;
                span = '0;
            end
            if (ch < nch) span[ch] = 1'b1;
        end
    endtask

    // Work out the events of one accepted trace word and advance the state
    task automatic predict_word(input t_in req);
        logic [SAMPLE_W-1:0] smp;
        word_events.delete();
        if (req.first_word) begin
            tick_now = '0;
            halted = 1'b0;
        end
        if (!halted) begin
            if (req.trace_word[31]) begin
                smp = req.trace_word[30:16];
                if (req.first_word) last_sample = ~smp;
                collect_group_changes(tick_now, smp, last_sample);
                last_sample = smp;
                tick_now = add_ticks(tick_now, {15'd0, req.trace_word[15:0], 1'b0});
                halted = (tick_now > limit_cfg);
            end else begin
                smp = req.trace_word[14:0];
                if (req.first_word) last_sample = ~smp;
                collect_group_changes(tick_now, smp, last_sample);
                last_sample = smp;
                tick_now = add_ticks(tick_now, 32'd1);
                if (tick_now > limit_cfg) begin
                    halted = 1'b1;
                end else begin
                    // second sample of the pair, bit 15 skipped
                    smp = req.trace_word[30:16];
                    collect_group_changes(tick_now, smp, last_sample);
                    last_sample = smp;
                    tick_now = add_ticks(tick_now, 32'd1);
                    halted = (tick_now > limit_cfg);
                end
            end
        end
        if (word_events.size() != 0) word_events[word_events.size() - 1].last_event = 1'b1;
        expected_events = {expected_events, word_events};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Idle length: mostly none, often short, rarely long, with calm stretches
    function automatic int idle_length(inout int calm_left);
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 5) return $urandom_range(8, 40);
        if (roll < 40) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Next sample: unchanged, one bit flipped, a few bits flipped or fresh
    function automatic logic [SAMPLE_W-1:0] next_sample();
        case ($urandom_range(0, 3))
            0: gen_sample = gen_sample;
            1: gen_sample = gen_sample ^ (15'd1 << $urandom_range(0, 14));
            2: gen_sample = gen_sample ^ (15'($urandom) & 15'($urandom));
            default: gen_sample = 15'($urandom);
        endcase
        return gen_sample;
    endfunction

    function automatic t_in random_word(input logic first);
        t_in req;
        logic [SAMPLE_W-1:0] lo_s;
        logic [SAMPLE_W-1:0] hi_s;
        logic [15:0] count;
        lo_s = next_sample();
        hi_s = next_sample();
        case ($urandom_range(0, 9))
            0: count = 16'hFFFF;
            1: count = 16'h0000;
            2: count = 16'($urandom);
            default: count = 16'($urandom_range(1, 8));
        endcase
        req.first_word = first;
        if ($urandom_range(0, 1) == 1) req.trace_word = {1'b1, lo_s, count};
        else req.trace_word = {1'b0, hi_s, 1'($urandom), lo_s};
        return req;
    endfunction

    task automatic queue_word(input logic first, input logic [31:0] word);
        t_in req;
        req.first_word = first;
        req.trace_word = word;
        pending_words = {pending_words, req};
    endtask

    // Wait until every request is in and every event out, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_GROUP_START_MASK: start_mask_cfg = val[SAMPLE_W-1:0];
            CFG_CHANNEL_COUNT:    chan_count_cfg = val[COUNT_W-1:0];
            CFG_TIME_LIMIT:       limit_cfg = val;
            default: ;
        endcase
    endtask

    task automatic random_phase(input logic [SAMPLE_W-1:0] mask, input logic [COUNT_W-1:0] chans,
                                input logic [TIME_W-1:0] lim, input int n);
        drain();
        write_reg(CFG_GROUP_START_MASK, {17'd0, mask});
        write_reg(CFG_CHANNEL_COUNT, {28'd0, chans});
        write_reg(CFG_TIME_LIMIT, lim);
        pending_words = {pending_words, random_word(1'b1)};
        for (int k = 1; k < n; k++)
            pending_words = {pending_words, random_word($urandom_range(0, 11) == 0)};
    endtask

    // Driver: present queued requests with random gaps, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_word(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    i_in <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap = idle_length(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted event against the oldest expected one, stall at random
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected event, time", o_out.event_time, 32'd0);
            end else begin
                want = expected_events.pop_front();
                if (o_out.event_time !== want.event_time)
                    report_mismatch("event_time", o_out.event_time, want.event_time);
                if (o_out.group_index !== want.group_index)
                    report_mismatch("group_index", 32'(o_out.group_index), 32'(want.group_index));
                if (o_out.group_value !== want.group_value)
                    report_mismatch("group_value", 32'(o_out.group_value), 32'(want.group_value));
                if (o_out.last_event !== want.last_event)
                    report_mismatch("last_event", 32'(o_out.last_event), 32'(want.last_event));
            end
        end
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            out_hold = idle_length(out_calm);
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("grouped_signal_trace_decoder_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one group; a word before any first word compares against zero
        queue_word(1'b0, 32'h0003_0001);
        queue_word(1'b1, {1'b1, 15'h7FFF, 16'h0000});
        queue_word(1'b0, {1'b1, 15'h0000, 16'hFFFF});
        drain();

        // Channel zero starts a group even with its start bit clear; bit 15 of a pair ignored
        write_reg(CFG_GROUP_START_MASK, 32'h0000_2AAA);
        write_reg(CFG_CHANNEL_COUNT, 32'd15);
        write_reg(CFG_TIME_LIMIT, 32'hFFFF_FFFF);
        queue_word(1'b1, 32'h7FFF_8000);
        queue_word(1'b0, 32'h5555_AAAA);
        queue_word(1'b0, {1'b1, 15'h5555, 16'h0001});
        drain();

        // Every channel its own group: thirty events from one pair
        write_reg(CFG_GROUP_START_MASK, 32'h0000_7FFF);
        queue_word(1'b1, 32'h0000_7FFF);
        queue_word(1'b0, 32'h7FFF_0000);
        drain();

        // Start bits above the channel count have no effect
        write_reg(CFG_GROUP_START_MASK, 32'h0000_7FE0);
        write_reg(CFG_CHANNEL_COUNT, 32'd5);
        queue_word(1'b1, 32'h7FE0_001F);
        queue_word(1'b0, 32'h7FFF_7FE0);
        drain();

        // No channels, then a single channel
        write_reg(CFG_CHANNEL_COUNT, 32'd0);
        queue_word(1'b1, 32'h1234_5678);
        queue_word(1'b0, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_CHANNEL_COUNT, 32'd1);
        queue_word(1'b1, 32'h0001_0000);
        queue_word(1'b0, 32'hFFFE_7FFE);
        drain();

        // Limit zero: stop inside a pair, ignore words until the next first word
        write_reg(CFG_GROUP_START_MASK, 32'h0000_0001);
        write_reg(CFG_CHANNEL_COUNT, 32'd15);
        write_reg(CFG_TIME_LIMIT, 32'd0);
        queue_word(1'b1, 32'h7FFF_0000);
        queue_word(1'b0, 32'h1111_2222);
        queue_word(1'b1, {1'b1, 15'h0F0F, 16'h0000});
        drain();

        // Limit four: run up to the limit, then stop after the first half of a pair
        write_reg(CFG_TIME_LIMIT, 32'd4);
        queue_word(1'b1, {1'b1, 15'h0001, 16'd2});
        queue_word(1'b0, 32'h0003_0002);
        queue_word(1'b0, 32'h0000_0000);
        drain();

        // Long unchanged runs, then change every group
        write_reg(CFG_GROUP_START_MASK, 32'h0000_0421);
        write_reg(CFG_TIME_LIMIT, 32'hFFFF_FFFF);
        queue_word(1'b1, {1'b1, 15'h1234, 16'hFFFF});
        repeat (LONG_RUNS) queue_word(1'b0, {1'b1, 15'h1234, 16'hFFFF});
        queue_word(1'b0, 32'h0000_4321);
        queue_word(1'b0, {1'b1, 15'h4321, 16'h0001});

        // Random words under a range of settings
        random_phase(15'($urandom), 4'd15, 32'hFFFF_FFFF, 64);
        random_phase(15'h7FFF, 4'd15, 32'd300, 64);
        random_phase(15'($urandom), 4'($urandom), 32'($urandom_range(0, 2000)), 64);
        random_phase(15'h0000, 4'd15, 32'($urandom), 64);
        random_phase(15'($urandom), 4'($urandom_range(1, 14)), 32'($urandom_range(20, 400)), 64);
        drain();

        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("grouped_signal_trace_decoder_top_tb OK");
        end else begin
            $display("grouped_signal_trace_decoder_top_tb NOT OK");
        end
        $finish;
    end

endmodule
